@@ rtl/tcee_pkg.sv @@
// tcee_pkg: shared types, character codes and helper functions for the
// text cell escape encoder; no dependencies
package tcee_pkg;

   localparam int unsigned MaxBytes = 9;
   localparam int unsigned IdxWidth = $clog2(MaxBytes);

   typedef logic [7:0]          byte_type;
   typedef logic [IdxWidth-1:0] idx_type;

   // attribute value after reset; the first cell shows its attribute unless it carries this value
   localparam logic [15:0] ATTR_RESET = 16'd6666;

   localparam byte_type CHR_BSLASH = 8'h5C;
   localparam byte_type CHR_DASH   = 8'h2D;
   localparam byte_type CHR_G      = 8'h67;
   localparam byte_type CHR_N      = 8'h6E;
   localparam byte_type CHR_LOW_V  = 8'h76;
   localparam byte_type CHR_UP_V   = 8'h56;
   localparam byte_type CHR_SPACE  = 8'h20;

   // register indexes of the configuration port
   localparam logic [1:0] REG_ENCODE_MODE = 2'd0;
   localparam logic [1:0] REG_TRANSP_CHAR = 2'd1;
   localparam logic [1:0] REG_TRANSP_BG   = 2'd2;
   localparam logic [1:0] REG_TRANSP_FG   = 2'd3;

   function automatic byte_type hex_digit(input logic [3:0] n);
      byte_type d;
      if (n < 4'd10) begin
         d = 8'h30 + {4'd0, n};
      end else begin
         d = 8'h41 + {4'd0, n - 4'd10};
      end
      return d;
   endfunction

   // space, digit or letter
   function automatic logic plain_byte(input byte_type c);
      return (c == CHR_SPACE) ||
             (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

endpackage

@@ rtl/text_cell_escape_encoder_unit.sv @@
// text_cell_escape_encoder_unit: turns screen cells into escaped text bytes
// depends on tcee_pkg (types, character codes, hex_digit, plain_byte)
//
//  channel | dir | handshake           | payload
//  req_    | in  | req_tvalid/tready   | tdata = cell_char, cell_attr; tlast = row_end
//  rsp_    | out | rsp_tvalid/tready   | tdata = out_char; tlast = last byte of the cell
//  csr_    | in  | csr_we (no wait)    | csr_index, csr_data
//
// an item passes through the input register, then its 1 to 9 bytes leave
// from the byte buffer at one byte per cycle while rsp_tready is high; the
// result port's byte rate, held by rsp_tready stalls, sets the throughput
// the next item is taken into the input register while the buffer still drains
// reset clears the valid flags and byte indexes, sets the configuration registers to mode 0 with
// no transparency (all ones) and the remembered attribute to 6666; a stall on rsp_tready holds
// the buffer and, once the input register is full, drops req_tready
module text_cell_escape_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] cell_char, [23:8] cell_attr
   input  logic        req_tlast,   // row_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_char
   output logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);

   // configuration
   logic [1:0] mode_ff;
   logic [8:0] tchar_ff;
   logic [4:0] tbg_ff;
   logic [4:0] tfg_ff;

   // input register
   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_char_ff;
   logic [15:0] in_attr_ff;
   logic        in_row_ff;

   // byte buffer
   tcee_pkg::byte_type buf_ff [tcee_pkg::MaxBytes];
   tcee_pkg::byte_type buf_in [tcee_pkg::MaxBytes];
   logic               buf_vld_ff, buf_vld_in;
   tcee_pkg::idx_type  idx_ff, idx_in;
   tcee_pkg::idx_type  lst_ff, lst_in;
   logic [15:0]        prev_attr_ff;

   logic take, drained, load, accept;

   assign take    = buf_vld_ff && rsp_tready;
   assign drained = take && (idx_ff == lst_ff);
   assign load    = in_vld_ff && (!buf_vld_ff || drained);
   assign accept  = req_tvalid && req_tready;

   assign req_tready = !in_vld_ff || load;
   assign rsp_tvalid = buf_vld_ff;
   assign rsp_tdata  = buf_ff[idx_ff];
   assign rsp_tlast  = (idx_ff == lst_ff);

   // encoding of the cell in the input register
   logic [3:0]         fg, bg;
   logic               attr_chg, no_tchar, transp, escape;
   tcee_pkg::byte_type attr_seq [3];
   tcee_pkg::byte_type char_seq [4];
   tcee_pkg::idx_type  alen, clen, rlen, total;

   always_comb begin
      fg       = in_attr_ff[3:0];
      bg       = in_attr_ff[7:4];
      attr_chg = (in_attr_ff != prev_attr_ff);
      no_tchar = tchar_ff[8];

      attr_seq[0] = tcee_pkg::CHR_BSLASH;
      attr_seq[1] = (!tfg_ff[4] && tfg_ff[3:0] == fg && no_tchar) ?
                    tcee_pkg::CHR_LOW_V : tcee_pkg::hex_digit(fg);
      attr_seq[2] = (!tbg_ff[4] && tbg_ff[3:0] == bg && no_tchar) ?
                    tcee_pkg::CHR_UP_V : tcee_pkg::hex_digit(bg);

      transp = !no_tchar && (tchar_ff[7:0] == in_char_ff) &&
               (tfg_ff == 5'h1F || (!tfg_ff[4] && tfg_ff[3:0] == fg)) &&
               (tbg_ff == 5'h1F || (!tbg_ff[4] && tbg_ff[3:0] == bg));
      escape = (mode_ff != 2'd0 || in_char_ff == tcee_pkg::CHR_BSLASH) &&
               (mode_ff[1] || !tcee_pkg::plain_byte(in_char_ff));

      char_seq[0] = tcee_pkg::CHR_BSLASH;
      char_seq[1] = tcee_pkg::CHR_DASH;
      char_seq[2] = tcee_pkg::hex_digit(in_char_ff[7:4]);
      char_seq[3] = tcee_pkg::hex_digit(in_char_ff[3:0]);
      if (transp) begin
         clen = tcee_pkg::idx_type'(2);
      end else if (escape) begin
         char_seq[1] = tcee_pkg::CHR_G;
         clen = tcee_pkg::idx_type'(4);
      end else begin
         char_seq[0] = in_char_ff;
         clen = tcee_pkg::idx_type'(1);
      end

      alen  = attr_chg ? tcee_pkg::idx_type'(3) : '0;
      rlen  = in_row_ff ? tcee_pkg::idx_type'(2) : '0;
      total = alen + clen + rlen;

      // place each output byte from the attribute, character or row-end run
      for (int k = 0; k < tcee_pkg::MaxBytes; k++) begin
         if (tcee_pkg::idx_type'(k) < alen) begin
            buf_in[tcee_pkg::idx_type'(k)] = attr_seq[2'(k % 3)];
         end else if (tcee_pkg::idx_type'(k) < alen + clen) begin
            buf_in[tcee_pkg::idx_type'(k)] = char_seq[2'(tcee_pkg::idx_type'(k) - alen)];
         end else if (tcee_pkg::idx_type'(k) == alen + clen) begin
            buf_in[tcee_pkg::idx_type'(k)] = tcee_pkg::CHR_BSLASH;
         end else begin
            buf_in[tcee_pkg::idx_type'(k)] = tcee_pkg::CHR_N;
         end
      end
   end

   // control next values
   always_comb begin
      in_vld_in  = in_vld_ff;
      buf_vld_in = buf_vld_ff;
      idx_in     = idx_ff;
      lst_in     = lst_ff;
      if (load) begin
         in_vld_in = 1'b0;
      end
      if (accept) begin
         in_vld_in = 1'b1;
      end
      if (take) begin
         idx_in = idx_ff + tcee_pkg::idx_type'(1);
      end
      if (drained) begin
         buf_vld_in = 1'b0;
      end
      if (load) begin
         buf_vld_in = 1'b1;
         idx_in     = '0;
         lst_in     = total - tcee_pkg::idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         buf_vld_ff   <= 1'b0;
         idx_ff       <= '0;
         lst_ff       <= '0;
         prev_attr_ff <= tcee_pkg::ATTR_RESET;
         mode_ff      <= 2'd0;
         tchar_ff     <= 9'h1FF;
         tbg_ff       <= 5'h1F;
         tfg_ff       <= 5'h1F;
      end else begin
         in_vld_ff  <= in_vld_in;
         buf_vld_ff <= buf_vld_in;
         idx_ff     <= idx_in;
         lst_ff     <= lst_in;
         if (load) begin
            prev_attr_ff <= in_attr_ff;
         end
         if (csr_we) begin
            case (csr_index)
               tcee_pkg::REG_ENCODE_MODE: mode_ff  <= csr_data[1:0];
               tcee_pkg::REG_TRANSP_CHAR: tchar_ff <= csr_data;
               tcee_pkg::REG_TRANSP_BG:   tbg_ff   <= csr_data[4:0];
               tcee_pkg::REG_TRANSP_FG:   tfg_ff   <= csr_data[4:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_tdata[7:0];
         in_attr_ff <= req_tdata[23:8];
         in_row_ff  <= req_tlast;
      end
      if (load) begin
         buf_ff <= buf_in;
      end
   end

endmodule

@@ dv/escape_stream_checker.sv @@
`timescale 1ns / 1ps
// escape_stream_checker: watches the cell, byte and register ports of the
// text cell escape encoder, predicts the escaped byte stream and compares it
// depends on tcee_pkg (register indexes, attribute reset value)
module escape_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] cell_char, [23:8] cell_attr
   input  logic        req_tlast,   // row_end
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // [7:0] out_char
   input  logic        rsp_tlast,   // last
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data,
   output int          mismatches,
   output int          bytes_pending
);

   typedef struct packed {
      logic [7:0] text;
      logic       tail;
   } text_byte_type;

   text_byte_type expected_bytes[$];

   // shadow copies of the registers and the remembered attribute
   logic [1:0]        enc_mode;
   logic signed [8:0] xp_char;
   logic signed [4:0] xp_bg;
   logic signed [4:0] xp_fg;
   logic [15:0]       prev_attr;

   initial begin
      mismatches = 0;
      bytes_pending = 0;
   end

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("%0t: mismatch, %s", $time, what);
   endtask

   function automatic logic [7:0] ascii_hex(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + v : 8'h37 + v;
   endfunction

   function automatic logic is_plain(input logic [7:0] c);
      return c == 8'h20 || (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
   endfunction

   // appends the bytes that one cell turns into
   function automatic void expand_cell(input logic [7:0] ch, input logic [15:0] attr,
                                       input logic row_end);
      logic [7:0] seq[$];
      int fg;
      int bg;
      int t_char;
      int t_bg;
      int t_fg;
      text_byte_type b;
      fg = attr[3:0];
      bg = attr[7:4];
      t_char = xp_char;
      t_bg = xp_bg;
      t_fg = xp_fg;
      if (attr != prev_attr) begin
         seq.push_back(8'h5C);
         seq.push_back((fg == t_fg && t_char < 0) ? 8'h76 : ascii_hex(attr[3:0]));
         seq.push_back((bg == t_bg && t_char < 0) ? 8'h56 : ascii_hex(attr[7:4]));
      end
      if (t_char >= 0 && int'(ch) == t_char && (t_fg == -1 || t_fg == fg) &&
          (t_bg == -1 || t_bg == bg)) begin
         seq.push_back(8'h5C);
         seq.push_back(8'h2D);
      end else if ((enc_mode != 2'd0 || ch == 8'h5C) && (enc_mode > 2'd1 || !is_plain(ch))) begin
         seq.push_back(8'h5C);
         seq.push_back(8'h67);
         seq.push_back(ascii_hex(ch[7:4]));
         seq.push_back(ascii_hex(ch[3:0]));
      end else begin
         seq.push_back(ch);
      end
      if (row_end) begin
         seq.push_back(8'h5C);
         seq.push_back(8'h6E);
      end
      prev_attr = attr;
      foreach (seq[k]) begin
         b.text = seq[k];
         b.tail = (k == seq.size() - 1);
         expected_bytes.push_back(b);
      end
   endfunction

   always @(posedge clock) begin : watch
      text_byte_type head;
      if (reset) begin
         expected_bytes.delete();
         enc_mode = 2'd0;
         xp_char = -9'sd1;
         xp_bg = -5'sd1;
         xp_fg = -5'sd1;
         prev_attr = tcee_pkg::ATTR_RESET;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tcee_pkg::REG_ENCODE_MODE: enc_mode = csr_data[1:0];
               tcee_pkg::REG_TRANSP_CHAR: xp_char = csr_data;
               tcee_pkg::REG_TRANSP_BG:   xp_bg = csr_data[4:0];
               tcee_pkg::REG_TRANSP_FG:   xp_fg = csr_data[4:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expand_cell(req_tdata[7:0], req_tdata[23:8], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               note_mismatch($sformatf("byte %02h with nothing outstanding", rsp_tdata));
            end else begin
               head = expected_bytes.pop_front();
               if (rsp_tdata !== head.text) begin
                  note_mismatch($sformatf("out_char %02h, wanted %02h", rsp_tdata, head.text));
               end
               if (rsp_tlast !== head.tail) begin
                  note_mismatch($sformatf("last %b, wanted %b", rsp_tlast, head.tail));
               end
            end
         end
      end
      bytes_pending = expected_bytes.size();
   end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// tb: drives screen cells and register writes into the escape encoder and
// gives the verdict; depends on tcee_pkg, the encoder unit and escape_stream_checker
module tb;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [7:0] cell_char, [23:8] cell_attr
   logic        req_tlast;   // row_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [7:0] out_char
   logic        rsp_tlast;   // last
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [8:0]  csr_data;

   int mismatches;
   int bytes_pending;
   int tx_idle_pct = 29;
   int rx_idle_pct = 75;
   int sent_items = 0;
   int hold_after = 32'h7fffffff;
   bit hold_done = 1'b0;

   // register values as last written, for steering the random cells
   int cfg_char = -1;
   int cfg_bg = -1;
   int cfg_fg = -1;
   logic [15:0] last_attr = tcee_pkg::ATTR_RESET;

   int phase_mode[6] = '{1, 2, 3, 0, 1, 0};
   int phase_char[6] = '{-1, 8'h2E, 255, -256, 8'h5C, 0};
   int phase_bg[6]   = '{15, -1, 3, -16, -1, 0};
   int phase_fg[6]   = '{0, -1, 12, -2, 7, 15};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   text_cell_escape_encoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   escape_stream_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .mismatches    (mismatches),
      .bytes_pending (bytes_pending)
   );

   initial begin : watchdog
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   // byte sink, with one long hold-off so the encoder backs up into its input
   initial begin : byte_sink
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && sent_items >= hold_after) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (80) @(negedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_cell(input logic [7:0] ch, input logic [15:0] attr, input logic row_end);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {attr, ch};
      req_tlast <= row_end;
      last_attr = attr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
   endtask

   // waits until every byte is out and the encoder has gone quiet
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (bytes_pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic configure(input int mode, input int tchar, input int tbg, input int tfg);
      drain();
      csr_we <= 1'b1;
      csr_index <= tcee_pkg::REG_ENCODE_MODE;
      csr_data <= 9'(mode);
      @(negedge clock);
      csr_index <= tcee_pkg::REG_TRANSP_CHAR;
      csr_data <= 9'(tchar);
      @(negedge clock);
      csr_index <= tcee_pkg::REG_TRANSP_BG;
      csr_data <= 9'(tbg);
      @(negedge clock);
      csr_index <= tcee_pkg::REG_TRANSP_FG;
      csr_data <= 9'(tfg);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_char = tchar;
      cfg_bg = tbg;
      cfg_fg = tfg;
   endtask

   task automatic send_random_cell();
      logic [7:0] ch;
      logic [15:0] attr;
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         case ($urandom_range(3))
            0: ch = tcee_pkg::CHR_SPACE;
            1: ch = 8'($urandom_range(8'h39, 8'h30));
            2: ch = 8'($urandom_range(8'h5A, 8'h41));
            default: ch = 8'($urandom_range(8'h7A, 8'h61));
         endcase
      end else if (pick < 45) begin
         ch = 8'($urandom_range(47, 33));
      end else if (pick < 55) begin
         ch = tcee_pkg::CHR_BSLASH;
      end else if (pick < 70 && cfg_char >= 0) begin
         ch = cfg_char[7:0];
      end else begin
         ch = 8'($urandom_range(255));
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
         attr = last_attr;
      end else if (pick < 80) begin
         // nibbles steered onto the transparency registers
         attr = 16'($urandom);
         if (cfg_fg >= 0 && $urandom_range(1)) attr[3:0] = cfg_fg[3:0];
         if (cfg_bg >= 0 && $urandom_range(1)) attr[7:4] = cfg_bg[3:0];
      end else begin
         attr = 16'($urandom_range(65535));
      end
      send_cell(ch, attr, $urandom_range(99) < 20);
   endtask

   initial begin : stimulus
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_we = 1'b0;
      csr_index = tcee_pkg::REG_ENCODE_MODE;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // literal mode after reset; the first cell carries the reset attribute
      send_cell("A", tcee_pkg::ATTR_RESET, 1'b0);
      send_cell("z", tcee_pkg::ATTR_RESET, 1'b0);
      send_cell(tcee_pkg::CHR_SPACE, 16'h0000, 1'b0);
      send_cell(tcee_pkg::CHR_BSLASH, 16'h0000, 1'b0);
      send_cell("!", 16'h0000, 1'b1);
      send_cell(8'h00, 16'hFFFF, 1'b0);
      send_cell(8'hFF, 16'hFFFF, 1'b1);
      send_cell("9", 16'h00A5, 1'b0);

      // transparent nibbles shown as v and V, escaping of punctuation
      configure(1, -1, 4, 3);
      send_cell("a", 16'h0043, 1'b0);
      send_cell("$", 16'h0034, 1'b0);
      send_cell("$", 16'h0099, 1'b1);
      send_cell("Z", 16'h0099, 1'b1);

      // transparent character with any colour, escape of every byte
      configure(2, 8'h51, -1, -1);
      send_cell("Q", 16'h1234, 1'b0);
      send_cell("q", 16'h1234, 1'b0);
      send_cell("Q", 16'hABCD, 1'b1);

      // mode three, transparency only on matching nibbles
      configure(3, 8'h51, 5, 2);
      send_cell("Q", 16'h0052, 1'b0);
      send_cell("Q", 16'h0025, 1'b0);
      send_cell("Q", 16'h0057, 1'b1);

      for (int p = 0; p < 6; p++) begin
         if (p == 2) begin
            tx_idle_pct = 75;
            rx_idle_pct = 29;
         end
         if (p == 4) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         configure(phase_mode[p], phase_char[p], phase_bg[p], phase_fg[p]);
         if (p == 4) hold_after = sent_items + 3;
         repeat (15) send_random_cell();
      end

      drain();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
